### rtl/udf_pkg.sv
// ----------------------------------------------------------------------------
// udf_pkg
// Shared types, constants and register codes of the ultrasonic distance filter.
// ----------------------------------------------------------------------------
package udf_pkg;

    // Field widths
    localparam int ECHO_W   = 15;
    localparam int DIST_W   = 9;
    localparam int CM_W     = 10;   // raw conversion result, up to 561 cm
    localparam int CNT_W    = 4;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 3;

    // Default window length
    localparam int WINDOW_DEF = 5;

    // cm = floor(us * 343 / 20000) = (us * CM_MULT) >> CM_SHIFT, exact for 15-bit us
    localparam int CM_MULT_W = 25;
    localparam logic [CM_MULT_W-1:0] CM_MULT = 25'd18414673;
    localparam int CM_SHIFT  = 30;
    localparam int CM_PROD_W = ECHO_W + CM_MULT_W;

    // Window entries and the last accepted distance start from this value
    localparam logic [DIST_W-1:0] UNTOUCHED_CM = 9'd100;
    localparam int MAX_DIST = 511;

    // Register reset values
    localparam logic [DIST_W-1:0] MIN_RANGE_RST  = 9'd2;
    localparam logic [DIST_W-1:0] MAX_RANGE_RST  = 9'd400;
    localparam logic [DIST_W-1:0] JUMP_LIMIT_RST = 9'd50;
    localparam logic [CNT_W-1:0]  INV_LIMIT_RST  = 4'd3;
    localparam logic [DIST_W-1:0] FALLBACK_RST   = 9'd40;
    localparam logic [CNT_W-1:0]  CNT_MAX        = 4'hF;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_MIN_RANGE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX_RANGE  = 3'd1;
    localparam logic [IDX_W-1:0] REG_JUMP_LIMIT = 3'd2;
    localparam logic [IDX_W-1:0] REG_INV_LIMIT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_FALLBACK   = 3'd4;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_NEW_AVG   = 2'd0,
        ST_SPIKE     = 2'd1,
        ST_INVALID   = 2'd2,
        ST_FALLBACK  = 2'd3
    } t_status;

endpackage

### rtl/udf_if.sv
// ----------------------------------------------------------------------------
// udf_if
// Handshake channels of the distance filter: echo in, result out, register write.
// ----------------------------------------------------------------------------
interface udf_in_if;
    logic                          valid;
    logic                          ready;
    logic [udf_pkg::ECHO_W-1:0]    echo_us;

    modport source (output valid, output echo_us, input ready);
    modport sink   (input valid, input echo_us, output ready);
endinterface

interface udf_out_if;
    logic                          valid;
    logic                          ready;
    logic [udf_pkg::DIST_W-1:0]    distance_cm;
    logic [udf_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output distance_cm, output status, input ready);
    modport sink   (input valid, input distance_cm, input status, output ready);
endinterface

interface udf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [udf_pkg::IDX_W-1:0]     index;
    logic [udf_pkg::DIST_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/udf_cell.sv
// ----------------------------------------------------------------------------
// udf_cell
// One window entry: takes its neighbour's value on a shift, starts at 100 cm.
// ----------------------------------------------------------------------------
module udf_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  logic [udf_pkg::DIST_W-1:0] i_d,
    output logic [udf_pkg::DIST_W-1:0] o_q
);

    logic [udf_pkg::DIST_W-1:0] r_q;

    // entry register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= udf_pkg::UNTOUCHED_CM;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

### rtl/udf_window.sv
// ----------------------------------------------------------------------------
// udf_window
// Row of window cells with a running sum; the oldest entry drops off the end.
// ----------------------------------------------------------------------------
module udf_window #(
    parameter int WINDOW = udf_pkg::WINDOW_DEF,
    parameter int SUM_W  = $clog2(WINDOW * udf_pkg::MAX_DIST + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  logic [udf_pkg::DIST_W-1:0] i_cm,
    output logic [SUM_W-1:0]           o_sum
);

    localparam logic [SUM_W-1:0] SUM_RST = SUM_W'(WINDOW * 100);

    logic [udf_pkg::DIST_W-1:0] w_tap [WINDOW+1];
    logic [SUM_W-1:0]           r_sum;
    logic [SUM_W-1:0]           n_sum;

    assign w_tap[0] = i_cm;

    // chain of cells, newest at the head
    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        udf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_d     (w_tap[k]),
            .o_q     (w_tap[k+1])
        );
    end

    // running sum: add newest, drop oldest
    always_comb begin
        n_sum = r_sum + SUM_W'(i_cm) - SUM_W'(w_tap[WINDOW]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= SUM_RST;
        end else if (i_shift) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

### rtl/ultrasonic_distance_filter.sv
// ----------------------------------------------------------------------------
// ultrasonic_distance_filter
// Echo width to distance, moving average with spike rejection and fallback.
// ----------------------------------------------------------------------------
// Takes one echo width per cycle while the output is not stalled and gives
// one result per echo, presented from stage r4 after stages r1, r2 and r3.
// The echo is scaled to cm by a reciprocal multiply, an in-range reading
// shifts into a row of WINDOW cells whose running sum is updated in the same
// cycle, the sum is divided by WINDOW through a second reciprocal multiply,
// and the last stage applies the jump test and the invalid counter. A stalled
// output only holds the stages that are full; empty stages keep taking input.
// Registers are written through the configuration channel, which is always
// ready.
module ultrasonic_distance_filter #(
    parameter int WINDOW = udf_pkg::WINDOW_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    udf_in_if.sink    i_in,
    udf_out_if.source o_out,
    udf_cfg_if.sink   i_cfg
);

    localparam int SUM_W  = $clog2(WINDOW * udf_pkg::MAX_DIST + 1);
    localparam int AVG_L  = $clog2(WINDOW);
    localparam int AVG_SH = SUM_W + AVG_L;
    localparam int M_W    = AVG_SH + 1;
    localparam logic [M_W-1:0] AVG_M = M_W'(((1 << AVG_SH) + WINDOW - 1) / WINDOW);
    localparam int AP_W   = SUM_W + M_W;

    // configuration registers
    logic [udf_pkg::DIST_W-1:0] r_min_range;
    logic [udf_pkg::DIST_W-1:0] r_max_range;
    logic [udf_pkg::DIST_W-1:0] r_jump_limit;
    logic [udf_pkg::CNT_W-1:0]  r_inv_limit;
    logic [udf_pkg::DIST_W-1:0] r_fallback;

    // pipeline
    logic                          r1_v;
    logic [udf_pkg::CM_PROD_W-1:0] r1_prod;
    logic                          r2_v;
    logic                          r2_ok;
    logic                          r3_v;
    logic                          r3_ok;
    logic [AP_W-1:0]               r3_prod;
    logic                          r4_v;
    logic [udf_pkg::DIST_W-1:0]    r4_dist;
    udf_pkg::t_status              r4_status;

    // filter state
    logic [udf_pkg::DIST_W-1:0]    r_last;
    logic [udf_pkg::CNT_W-1:0]     r_bad;

    logic                          e1, e2, e3, e4;
    logic [udf_pkg::CM_W-1:0]      w_cm;
    logic                          w_ok;
    logic                          w_shift;
    logic [SUM_W-1:0]              w_sum;
    logic [udf_pkg::DIST_W-1:0]    w_avg;
    logic [udf_pkg::DIST_W-1:0]    w_diff;
    logic [udf_pkg::CNT_W-1:0]     w_bad_inc;
    logic [udf_pkg::DIST_W-1:0]    n_last;
    logic [udf_pkg::CNT_W-1:0]     n_bad;
    logic [udf_pkg::DIST_W-1:0]    n_dist;
    udf_pkg::t_status              n_status;

    // stage enables, rippled back from the output
    assign e4 = !r4_v || o_out.ready;
    assign e3 = !r3_v || e4;
    assign e2 = !r2_v || e3;
    assign e1 = !r1_v || e2;

    assign i_in.ready  = e1;
    assign i_cfg.ready = 1'b1;

    // register writes; unknown indexes fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range  <= udf_pkg::MIN_RANGE_RST;
            r_max_range  <= udf_pkg::MAX_RANGE_RST;
            r_jump_limit <= udf_pkg::JUMP_LIMIT_RST;
            r_inv_limit  <= udf_pkg::INV_LIMIT_RST;
            r_fallback   <= udf_pkg::FALLBACK_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                udf_pkg::REG_MIN_RANGE:  r_min_range  <= i_cfg.data;
                udf_pkg::REG_MAX_RANGE:  r_max_range  <= i_cfg.data;
                udf_pkg::REG_JUMP_LIMIT: r_jump_limit <= i_cfg.data;
                udf_pkg::REG_INV_LIMIT:  r_inv_limit  <= i_cfg.data[udf_pkg::CNT_W-1:0];
                udf_pkg::REG_FALLBACK:   r_fallback   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // stage 2: range check on the scaled echo
    always_comb begin
        w_cm    = r1_prod[udf_pkg::CM_SHIFT +: udf_pkg::CM_W];
        w_ok    = (w_cm != '0)
               && (w_cm >= udf_pkg::CM_W'(r_min_range))
               && (w_cm <= udf_pkg::CM_W'(r_max_range));
        w_shift = e2 && r1_v && w_ok;
    end

    udf_window #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_shift),
        .i_cm    (w_cm[udf_pkg::DIST_W-1:0]),
        .o_sum   (w_sum)
    );

    // stage 4: jump test and invalid counting
    always_comb begin
        w_avg     = r3_prod[AVG_SH +: udf_pkg::DIST_W];
        w_diff    = (w_avg > r_last) ? (w_avg - r_last) : (r_last - w_avg);
        w_bad_inc = (r_bad == udf_pkg::CNT_MAX) ? r_bad : (r_bad + 1'b1);
        n_last    = r_last;
        n_bad     = r_bad;
        n_dist    = r_last;
        n_status  = udf_pkg::ST_NEW_AVG;
        if (r3_ok) begin
            if ((w_diff > r_jump_limit) && (r_last != udf_pkg::UNTOUCHED_CM)) begin
                n_status = udf_pkg::ST_SPIKE;
            end else begin
                n_last = w_avg;
                n_bad  = '0;
                n_dist = w_avg;
            end
        end else begin
            n_bad = w_bad_inc;
            if (w_bad_inc >= r_inv_limit) begin
                n_dist   = r_fallback;
                n_status = udf_pkg::ST_FALLBACK;
            end else begin
                n_status = udf_pkg::ST_INVALID;
            end
        end
    end

    // stage valids and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r4_v   <= 1'b0;
            r_last <= udf_pkg::UNTOUCHED_CM;
            r_bad  <= '0;
        end else begin
            if (e1) begin
                r1_v <= i_in.valid;
            end
            if (e2) begin
                r2_v <= r1_v;
            end
            if (e3) begin
                r3_v <= r2_v;
            end
            if (e4) begin
                r4_v <= r3_v;
                if (r3_v) begin
                    r_last <= n_last;
                    r_bad  <= n_bad;
                end
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (e1) begin
            r1_prod <= udf_pkg::CM_PROD_W'(i_in.echo_us)
                     * udf_pkg::CM_PROD_W'(udf_pkg::CM_MULT);
        end
        if (e2) begin
            r2_ok <= w_ok;
        end
        if (e3) begin
            r3_ok   <= r2_ok;
            r3_prod <= AP_W'(w_sum) * AP_W'(AVG_M);
        end
        if (e4) begin
            r4_dist   <= n_dist;
            r4_status <= n_status;
        end
    end

    assign o_out.valid       = r4_v;
    assign o_out.distance_cm = r4_dist;
    assign o_out.status      = r4_status;

endmodule
